// ----- rtl/rgb_conv3x3_div_offset_clamp_core_macros.svh -----
// Assertion macros for the 3x3 RGB convolution core.
// Used by the top level; the clock is aclk and the active-low reset is aresetn.
`ifndef RGB_CONV3X3_DIV_OFFSET_CLAMP_CORE_MACROS_SVH
`define RGB_CONV3X3_DIV_OFFSET_CLAMP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RGBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgbc assertion failed");
`define RGBC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgbc assertion failed");
`else
`define RGBC_ASSERT_IMP(label, ante, cons)
`define RGBC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/rgbc_pkg.sv -----
// Shared types and constants of the 3x3 RGB convolution core.
// No dependencies.
package rgbc_pkg;

    localparam int COL_W         = 13;
    localparam int ROW_W         = 16;
    localparam int PIX_W         = 24;
    localparam int LW_W          = 14;
    localparam int DIV_W         = 12;
    localparam int OFF_W         = 16;
    localparam int COEF_W        = 24;
    localparam int SUM_W         = 20;
    localparam int MAG_W         = 19;
    localparam int MAX_WIDTH_DEF = 8192;
    localparam int COL_LIMIT     = 8192;
    localparam int MIN_DIM       = 3;
    localparam int QDEPTH        = 2;
    localparam int PIX_MAX       = 255;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    localparam int EMIT_HEAD = 0;
    localparam int EMIT_FILT = 1;
    localparam int EMIT_TAIL = 2;
    localparam int EMIT_CUR  = 3;
    localparam int EMIT_N    = 4;

    localparam logic [COEF_W-1:0] COEF_TOP_RST = 24'd197891;
    localparam logic [COEF_W-1:0] COEF_MID_RST = 24'd330245;
    localparam logic [COEF_W-1:0] COEF_BOT_RST = 24'd197891;
    localparam logic [DIV_W-1:0]  DIVISOR_RST  = 12'd42;
    localparam logic [OFF_W-1:0]  OFFSET_RST   = 16'd0;
    localparam logic [LW_W-1:0]   WIDTH_RST    = 14'd512;
    localparam logic [ROW_W-1:0]  HEIGHT_RST   = 16'd512;

    typedef enum logic [2:0] {
        REG_COEF_TOP,
        REG_COEF_MID,
        REG_COEF_BOT,
        REG_DIVISOR,
        REG_OFFSET,
        REG_LINE_WIDTH,
        REG_FRAME_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_column;
        logic             last;
    } pix_out_t;

    typedef struct packed {
        logic [COEF_W-1:0]       coef_top;
        logic [COEF_W-1:0]       coef_mid;
        logic [COEF_W-1:0]       coef_bot;
        logic [DIV_W-1:0]        divisor;
        logic signed [OFF_W-1:0] offset;
        logic [LW_W-1:0]         line_width;
        logic [ROW_W-1:0]        frame_height;
    } cfg_t;

    typedef struct packed {
        logic [EMIT_N-1:0]   mask;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [5:0][PIX_W-1:0] win;
        logic [PIX_W-1:0]    t2;
        logic [PIX_W-1:0]    t1;
        logic [PIX_W-1:0]    cur;
    } job_t;

endpackage

// ----- rtl/rgbc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rgbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rgbc_front.sv -----
// Front end: accepts pixels, tracks position, keeps line buffers and window.
// Depends on rgbc_pkg and rgbc_ram; emits one job into the queue per pixel with a non-zero mask.
module rgbc_front import rgbc_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    s_valid,
    output logic    s_ready,
    input  pix_in_t s_payload,
    input  logic    q_full,
    output logic    push,
    output job_t    job
);

    localparam int DEPTH = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
    localparam int AW    = $clog2(DEPTH);

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              pend_valid_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [PIX_W-1:0]  pend_cur_reg;
    logic [EMIT_N-1:0] pend_mask_reg;
    logic [ROW_W-1:0]  pend_row_reg;
    logic [COL_W-1:0]  pend_col_reg;
    logic [5:0][PIX_W-1:0] win_reg;

    logic [LW_W-1:0]   w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              endrow;
    logic              lastrow;
    logic [COL_W-1:0]  idx;
    logic [EMIT_N-1:0] mask;
    logic              accept;
    logic              done;
    logic [2*PIX_W-1:0] rdata;
    logic [PIX_W-1:0]  t2;
    logic [PIX_W-1:0]  t1;

    always_comb begin
        w_eff = cfg.line_width;
        if (w_eff > LW_W'(DEPTH)) begin
            w_eff = LW_W'(DEPTH);
        end
        if (w_eff < LW_W'(MIN_DIM)) begin
            w_eff = LW_W'(MIN_DIM);
        end
        h_eff = cfg.frame_height;
        if (h_eff < ROW_W'(MIN_DIM)) begin
            h_eff = ROW_W'(MIN_DIM);
        end
    end

    assign endrow  = {1'b0, col_reg} >= (w_eff - LW_W'(1));
    assign lastrow = row_reg >= (h_eff - ROW_W'(1));
    assign idx     = ({1'b0, col_reg} < LW_W'(DEPTH)) ? col_reg : COL_W'(DEPTH - 1);

    always_comb begin
        mask            = '0;
        mask[EMIT_HEAD] = (row_reg >= ROW_W'(2)) && (col_reg == '0);
        mask[EMIT_FILT] = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        mask[EMIT_TAIL] = (row_reg >= ROW_W'(2)) && (col_reg != '0) && endrow;
        mask[EMIT_CUR]  = (row_reg == '0) || lastrow;
    end

    assign t2      = rdata[2*PIX_W-1:PIX_W];
    assign t1      = rdata[PIX_W-1:0];
    assign push    = pend_valid_reg && (pend_mask_reg != '0) && !q_full;
    assign done    = pend_valid_reg && ((pend_mask_reg == '0) || !q_full);
    assign s_ready = !pend_valid_reg || done;
    assign accept  = s_valid && s_ready;

    rgbc_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (done),
        .waddr (pend_addr_reg),
        .wdata ({t1, pend_cur_reg}),
        .re    (accept),
        .raddr (idx[AW-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        job      = '0;
        job.mask = pend_mask_reg;
        job.row  = pend_row_reg;
        job.col  = pend_col_reg;
        job.win  = win_reg;
        job.t2   = t2;
        job.t1   = t1;
        job.cur  = pend_cur_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            win_reg        <= '0;
        end else begin
            if (done) begin
                pend_valid_reg <= 1'b0;
                win_reg[0]     <= win_reg[3];
                win_reg[1]     <= win_reg[4];
                win_reg[2]     <= win_reg[5];
                win_reg[3]     <= t2;
                win_reg[4]     <= t1;
                win_reg[5]     <= pend_cur_reg;
            end
            if (accept) begin
                pend_valid_reg <= 1'b1;
                pend_addr_reg  <= idx[AW-1:0];
                pend_cur_reg   <= s_payload;
                pend_mask_reg  <= mask;
                pend_row_reg   <= row_reg;
                pend_col_reg   <= col_reg;
                if (endrow) begin
                    col_reg <= '0;
                    row_reg <= lastrow ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

endmodule

// ----- rtl/rgbc_fifo.sv -----
// Short job queue between the front end and the back end.
// Depends on rgbc_pkg.
module rgbc_fifo import rgbc_pkg::*; #(
    parameter int DEPTH = QDEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t din,
    output logic full,
    input  logic pop,
    output job_t dout,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/rgbc_back.sv -----
// Back end: turns queued jobs into result transactions, with a shared
// multiply-accumulate over nine taps and a bit-serial divider. Depends on rgbc_pkg.
module rgbc_back import rgbc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     q_empty,
    input  job_t     q_dout,
    output logic     pop,
    output logic     m_valid,
    input  logic     m_ready,
    output pix_out_t m_payload
);

    localparam int TAP_LAST  = 8;
    localparam int STEP_LAST = MAG_W - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_TAP,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t            state_reg;
    job_t              job_reg;
    logic [EMIT_N-1:0] mask_reg;
    logic [3:0]        tap_reg;
    logic [4:0]        step_reg;
    logic signed [2:0][SUM_W-1:0] acc_reg;
    logic [2:0][MAG_W-1:0] dq_reg;
    logic [2:0][DIV_W-1:0] rem_reg;
    logic [2:0]        neg_reg;
    logic              m_valid_reg;
    pix_out_t          out_reg;

    logic [EMIT_N-1:0] low;
    logic [EMIT_N-1:0] rest;
    logic [PIX_W-1:0]  tap_px;
    logic [7:0]        tap_coef;
    logic signed [2:0][16:0] prod;
    logic [DIV_W-1:0]  dvs;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0][MAG_W-1:0] dq_new;
    logic [2:0][DIV_W-1:0] rem_new;
    logic [PIX_W-1:0]  filt;
    logic [PIX_W-1:0]  pass_px;
    logic [ROW_W-1:0]  pass_row;
    logic [COL_W-1:0]  pass_col;

    assign low     = mask_reg & (~mask_reg + EMIT_N'(1));
    assign rest    = mask_reg & ~low;
    assign pop     = (state_reg == ST_IDLE) && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_payload = out_reg;
    assign dvs     = (cfg.divisor == '0) ? DIV_W'(1) : cfg.divisor;

    always_comb begin
        case (tap_reg)
            4'd0: begin tap_px = job_reg.win[0]; tap_coef = cfg.coef_bot[7:0];   end
            4'd1: begin tap_px = job_reg.win[3]; tap_coef = cfg.coef_bot[15:8];  end
            4'd2: begin tap_px = job_reg.t2;     tap_coef = cfg.coef_bot[23:16]; end
            4'd3: begin tap_px = job_reg.win[1]; tap_coef = cfg.coef_mid[7:0];   end
            4'd4: begin tap_px = job_reg.win[4]; tap_coef = cfg.coef_mid[15:8];  end
            4'd5: begin tap_px = job_reg.t1;     tap_coef = cfg.coef_mid[23:16]; end
            4'd6: begin tap_px = job_reg.win[2]; tap_coef = cfg.coef_top[7:0];   end
            4'd7: begin tap_px = job_reg.win[5]; tap_coef = cfg.coef_top[15:8];  end
            4'd8: begin tap_px = job_reg.cur;    tap_coef = cfg.coef_top[23:16]; end
            default: begin tap_px = '0; tap_coef = '0; end
        endcase
    end

    always_comb begin
        logic [MAG_W-1:0]   q;
        logic signed [20:0] qs;
        logic signed [20:0] v;
        logic [DIV_W:0]     rem_sh;
        logic               ge;
        filt = '0;
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = $signed({1'b0, tap_px[8*ch +: 8]}) * $signed(tap_coef);
            mag[ch]  = acc_reg[ch][SUM_W-1] ? MAG_W'(-acc_reg[ch]) : MAG_W'(acc_reg[ch]);
            rem_sh   = {rem_reg[ch], dq_reg[ch][MAG_W-1]};
            ge       = rem_sh >= {1'b0, dvs};
            rem_new[ch] = ge ? DIV_W'(rem_sh - {1'b0, dvs}) : DIV_W'(rem_sh);
            dq_new[ch]  = {dq_reg[ch][MAG_W-2:0], ge};
            q  = dq_reg[ch];
            qs = neg_reg[ch] ? -$signed({2'b00, q}) : $signed({2'b00, q});
            v  = qs + 21'(cfg.offset);
            if (v < 0) begin
                filt[8*ch +: 8] = '0;
            end else if (v > $signed(21'(PIX_MAX))) begin
                filt[8*ch +: 8] = 8'(PIX_MAX);
            end else begin
                filt[8*ch +: 8] = v[7:0];
            end
        end
    end

    always_comb begin
        pass_px  = job_reg.t1;
        pass_row = job_reg.row - ROW_W'(1);
        pass_col = job_reg.col;
        if (low[EMIT_HEAD]) begin
            pass_col = '0;
        end else if (low[EMIT_CUR]) begin
            pass_px  = job_reg.cur;
            pass_row = job_reg.row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            mask_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_dout;
                        mask_reg  <= q_dout.mask;
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    if (low[EMIT_FILT]) begin
                        acc_reg   <= '0;
                        tap_reg   <= '0;
                        state_reg <= ST_TAP;
                    end else begin
                        out_reg.red_out    <= pass_px[7:0];
                        out_reg.green_out  <= pass_px[15:8];
                        out_reg.blue_out   <= pass_px[23:16];
                        out_reg.out_row    <= pass_row;
                        out_reg.out_column <= pass_col;
                        out_reg.last       <= rest == '0;
                        m_valid_reg        <= 1'b1;
                        state_reg          <= ST_OUT;
                    end
                end
                ST_TAP: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        acc_reg[ch] <= acc_reg[ch] + SUM_W'($signed(prod[ch]));
                    end
                    tap_reg <= tap_reg + 4'd1;
                    if (tap_reg == 4'(TAP_LAST)) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    for (int ch = 0; ch < 3; ch++) begin
                        neg_reg[ch] <= acc_reg[ch][SUM_W-1];
                        dq_reg[ch]  <= mag[ch];
                        rem_reg[ch] <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    dq_reg   <= dq_new;
                    rem_reg  <= rem_new;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(STEP_LAST)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    out_reg.red_out    <= filt[7:0];
                    out_reg.green_out  <= filt[15:8];
                    out_reg.blue_out   <= filt[23:16];
                    out_reg.out_row    <= job_reg.row - ROW_W'(1);
                    out_reg.out_column <= job_reg.col - COL_W'(1);
                    out_reg.last       <= rest == '0;
                    m_valid_reg        <= 1'b1;
                    state_reg          <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        mask_reg    <= rest;
                        state_reg   <= (rest == '0) ? ST_IDLE : ST_SEL;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/rgb_conv3x3_div_offset_clamp_core.sv -----
// Top level of the 3x3 RGB convolution core: register file, front end, queue, back end.
// Depends on rgbc_pkg, rgbc_front, rgbc_fifo, rgbc_back and the assertion macro header.
//
// Usage:
//  - s_valid/s_ready/s_payload carry raster-order RGB pixels; m_valid/m_ready/m_payload
//    carry results with their row and column, last marking the final result of a pixel.
//  - The APB port holds coefficients, divisor, offset, line width and frame height;
//    write it only while the core is idle.
//  - The front end takes one pixel per cycle while the job queue has room; the line
//    buffer read is registered beside the pixel, whose job then enters the queue.
//  - A pass-through result is formed in the back end's select state; a filtered result
//    runs through nine multiply-accumulate taps, a setup step, 19 steps of the
//    bit-serial divider and a finish step. The back end takes a new job only once it
//    has given out every result of the last one.
//  - Reset clears position counters, window, queue and the back end; line buffer
//    contents are not cleared and take no clearing pass.
//  - When the receiver stalls, the result register holds; the queue fills, then the
//    front end stops taking pixels.
`include "rgb_conv3x3_div_offset_clamp_core_macros.svh"
module rgb_conv3x3_div_offset_clamp_core import rgbc_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  pix_in_t            s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output pix_out_t           m_payload
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     pop;
    job_t     job_in;
    job_t     job_out;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_top     <= COEF_TOP_RST;
            cfg_reg.coef_mid     <= COEF_MID_RST;
            cfg_reg.coef_bot     <= COEF_BOT_RST;
            cfg_reg.divisor      <= DIVISOR_RST;
            cfg_reg.offset       <= OFFSET_RST;
            cfg_reg.line_width   <= WIDTH_RST;
            cfg_reg.frame_height <= HEIGHT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_COEF_TOP:     cfg_reg.coef_top     <= pwdata[COEF_W-1:0];
                REG_COEF_MID:     cfg_reg.coef_mid     <= pwdata[COEF_W-1:0];
                REG_COEF_BOT:     cfg_reg.coef_bot     <= pwdata[COEF_W-1:0];
                REG_DIVISOR:      cfg_reg.divisor      <= pwdata[DIV_W-1:0];
                REG_OFFSET:       cfg_reg.offset       <= pwdata[OFF_W-1:0];
                REG_LINE_WIDTH:   cfg_reg.line_width   <= pwdata[LW_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_TOP:     prdata = PDATA_W'(cfg_reg.coef_top);
            REG_COEF_MID:     prdata = PDATA_W'(cfg_reg.coef_mid);
            REG_COEF_BOT:     prdata = PDATA_W'(cfg_reg.coef_bot);
            REG_DIVISOR:      prdata = PDATA_W'(cfg_reg.divisor);
            REG_OFFSET:       prdata = PDATA_W'(unsigned'(cfg_reg.offset));
            REG_LINE_WIDTH:   prdata = PDATA_W'(cfg_reg.line_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(cfg_reg.frame_height);
            default:          prdata = '0;
        endcase
    end

    rgbc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .push      (push),
        .job       (job_in)
    );

    rgbc_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (job_in),
        .full    (q_full),
        .pop     (pop),
        .dout    (job_out),
        .empty   (q_empty)
    );

    rgbc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_dout    (job_out),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    `RGBC_ASSERT_IMP(a_no_overflow, push, !q_full)
    `RGBC_ASSERT_IMP(a_no_underflow, pop, !q_empty)
    `RGBC_ASSERT_NXT(a_pop_quiet_out, pop, !m_valid)

endmodule
